### hdl/ghr_pkg.sv
// Shared types and constants for the generational handle registry.
// No dependencies; imported by every module of the block.
package ghr_pkg;

	localparam int GEN_W        = 32;
	localparam int NUM_COUNTERS = 10;
	localparam int CNT_W        = 4;
	localparam int CNT_VAL_W    = 64;
	localparam int ROW_SHIFT    = 3;                  // 8 slots per life-state row
	localparam int LANE_W       = ROW_SHIFT;
	localparam int ROW_SLOTS    = 1 << ROW_SHIFT;
	localparam int LIFE_ROW_W   = 2 * ROW_SLOTS;

	typedef enum logic [2:0] {
		CMD_REGISTER  = 3'd0,
		CMD_RETIRE    = 3'd1,
		CMD_MARK_DEAD = 3'd2,
		CMD_PUBLISH   = 3'd3,
		CMD_QUERY     = 3'd4,
		CMD_READ_CNT  = 3'd5,
		CMD_CLEAR     = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_INVALID = 3'd2,
		ST_STALE   = 3'd3,
		ST_WRONG   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		LS_FREE     = 2'd0,
		LS_ACTIVE   = 2'd1,
		LS_RETIRING = 2'd2,
		LS_DEAD     = 2'd3
	} life_t;

	localparam logic [CNT_W-1:0] CNT_REG_OK      = 4'd0;
	localparam logic [CNT_W-1:0] CNT_REG_REUSE   = 4'd1;
	localparam logic [CNT_W-1:0] CNT_REG_FULL    = 4'd2;
	localparam logic [CNT_W-1:0] CNT_RETIRE_OK   = 4'd3;
	localparam logic [CNT_W-1:0] CNT_DEAD_OK     = 4'd4;
	localparam logic [CNT_W-1:0] CNT_PUB_ACCEPT  = 4'd5;
	localparam logic [CNT_W-1:0] CNT_PUB_STALE   = 4'd6;
	localparam logic [CNT_W-1:0] CNT_PUB_DEAD    = 4'd7;
	localparam logic [CNT_W-1:0] CNT_PUB_INVALID = 4'd8;
	localparam logic [CNT_W-1:0] CNT_BAD_TRANS   = 4'd9;

	typedef struct packed {
		logic                    clear;
		logic [NUM_COUNTERS-1:0] inc;
	} ctr_ctl_t;

endpackage

### hdl/ghr_slot_store.sv
// Slot storage: generation memory (one word per slot) and life-state memory
// (eight 2-bit states per row). Both read synchronously.
// Depends on ghr_pkg.
module ghr_slot_store #(
	parameter int SLOT_COUNT = 64
) (
	input  logic                            clk,
	input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] gen_rd_addr,
	input  logic                            gen_wr_en,
	input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] gen_wr_addr,
	input  logic [ghr_pkg::GEN_W-1:0]       gen_wr_data,
	output logic [ghr_pkg::GEN_W-1:0]       gen_rd_data,
	input  logic [((SLOT_COUNT + 7) / 8 > 1 ? $clog2((SLOT_COUNT + 7) / 8) : 1)-1:0] life_rd_row,
	input  logic                            life_wr_en,
	input  logic [((SLOT_COUNT + 7) / 8 > 1 ? $clog2((SLOT_COUNT + 7) / 8) : 1)-1:0] life_wr_row,
	input  logic [ghr_pkg::LIFE_ROW_W-1:0]  life_wr_data,
	output logic [ghr_pkg::LIFE_ROW_W-1:0]  life_rd_data
);
	import ghr_pkg::*;

	localparam int ROWS = (SLOT_COUNT + ROW_SLOTS - 1) / ROW_SLOTS;

	logic [GEN_W-1:0]      gen_mem  [SLOT_COUNT];
	logic [LIFE_ROW_W-1:0] life_mem [ROWS];

	always_ff @(posedge clk) begin
		if (gen_wr_en) begin
			gen_mem[gen_wr_addr] <= gen_wr_data;
		end
		gen_rd_data <= gen_mem[gen_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (life_wr_en) begin
			life_mem[life_wr_row] <= life_wr_data;
		end
		life_rd_data <= life_mem[life_rd_row];
	end

endmodule

### hdl/ghr_counters.sv
// Ten 64-bit wrapping event counters with a select read port.
// Depends on ghr_pkg (counter count, control struct).
module ghr_counters (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ghr_pkg::ctr_ctl_t           ctl,
	input  logic [ghr_pkg::CNT_W-1:0]   sel,
	output logic [ghr_pkg::CNT_VAL_W-1:0] value
);
	import ghr_pkg::*;

	logic [CNT_VAL_W-1:0] cnt_q [NUM_COUNTERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) cnt_q[i] <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < NUM_COUNTERS; i++) cnt_q[i] <= '0;
		end else begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				if (ctl.inc[i]) cnt_q[i] <= cnt_q[i] + CNT_VAL_W'(1);
			end
		end
	end

	assign value = (sel < CNT_W'(NUM_COUNTERS)) ? cnt_q[sel] : '0;

endmodule

### hdl/generational_handle_registry.sv
// Generational handle registry, top level: command sequencer around the slot
// memories and the event counters. Depends on ghr_pkg, ghr_slot_store, ghr_counters.
//
// An item is taken when start is high and busy is low; its result appears on the
// result ports for exactly one cycle with done high, and the receiver cannot hold
// it off. Retire, mark dead, publish check, query state, read counter and the
// unused code do one synchronous memory read, then the check and write-back;
// start may be raised again in the done cycle. Register scans the life-state
// memory one row of 8 slots per cycle, reading at most ceil(SLOT_COUNT/8) rows,
// and stops at the first row holding a dead slot; a full table is reported once
// the last row has been read. Clear zeroes the counters at once and sweeps both
// memories one slot per cycle. After reset the same sweep runs with busy high
// and no done.
module generational_handle_registry #(
	parameter int SLOT_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  command,
	input  logic [15:0] token_slot,
	input  logic [31:0] token_generation,
	input  logic [3:0]  counter_select,
	output logic        busy,
	output logic        done,
	output logic        success,
	output logic [2:0]  status_code,
	output logic [5:0]  granted_slot,
	output logic [31:0] granted_generation,
	output logic        slot_reused,
	output logic [1:0]  life_state,
	output logic [63:0] counter_value
);
	import ghr_pkg::*;

	localparam int SW   = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
	localparam int ROWS = (SLOT_COUNT + ROW_SLOTS - 1) / ROW_SLOTS;
	localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FETCH,
		S_GRANT,
		S_CLEAR
	} state_t;

	function automatic logic [1:0] life_get(input logic [LIFE_ROW_W-1:0] row,
	                                        input logic [LANE_W-1:0] lane);
		return row[{lane, 1'b0} +: 2];
	endfunction

	function automatic logic [LIFE_ROW_W-1:0] life_set(input logic [LIFE_ROW_W-1:0] row,
	                                                   input logic [LANE_W-1:0] lane,
	                                                   input life_t ls);
		logic [LIFE_ROW_W-1:0] r;
		r = row;
		r[{lane, 1'b0} +: 2] = ls;
		return r;
	endfunction

	state_t          state_q;
	cmd_t            cmd_q;
	logic [15:0]     slot_q;
	logic [GEN_W-1:0] gen_q;
	logic [CNT_W-1:0] sel_q;
	logic [RW-1:0]   row_s1;
	logic            have_free_q;
	logic [SW-1:0]   free_slot_q;
	logic [SW-1:0]   found_q;
	logic            reused_q;
	logic [SW-1:0]   clr_idx_q;
	logic            clr_reply_q;

	// memory ports
	logic [SW-1:0]         gen_rd_addr, gen_wr_addr;
	logic                  gen_wr_en;
	logic [GEN_W-1:0]      gen_wr_data, gen_rd_data;
	logic [RW-1:0]         life_rd_row, life_wr_row;
	logic                  life_wr_en;
	logic [LIFE_ROW_W-1:0] life_wr_data, life_rd_data;

	ctr_ctl_t             ctr_ctl;
	logic [CNT_VAL_W-1:0] ctr_value;

	// result of the item finishing this cycle
	logic             fin;
	logic             res_success;
	status_t          res_status;
	logic [5:0]       res_gslot;
	logic [GEN_W-1:0] res_ggen;
	logic             res_reused;
	logic [1:0]       res_life;
	logic [CNT_VAL_W-1:0] res_cval;

	// token check
	logic    tok_invalid, tok_stale;
	life_t   cur_life, need_life, next_life;

	// row scan
	logic [16:0]           row_base;
	logic [ROW_SLOTS-1:0]  dead_v, free_v;
	logic [LANE_W-1:0]     dead_idx, free_idx;
	logic                  scan_last;
	logic [GEN_W-1:0]      new_gen;

	ghr_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
		.clk          (clk),
		.gen_rd_addr  (gen_rd_addr),
		.gen_wr_en    (gen_wr_en),
		.gen_wr_addr  (gen_wr_addr),
		.gen_wr_data  (gen_wr_data),
		.gen_rd_data  (gen_rd_data),
		.life_rd_row  (life_rd_row),
		.life_wr_en   (life_wr_en),
		.life_wr_row  (life_wr_row),
		.life_wr_data (life_wr_data),
		.life_rd_data (life_rd_data)
	);

	ghr_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctr_ctl),
		.sel    (sel_q),
		.value  (ctr_value)
	);

	assign busy = (state_q != S_IDLE);

	// read address selection
	always_comb begin
		gen_rd_addr = SW'(token_slot);
		life_rd_row = RW'(token_slot >> ROW_SHIFT);
		unique case (state_q)
			S_IDLE: begin
				if (cmd_t'(command) == CMD_REGISTER) life_rd_row = '0;
			end
			S_SCAN: life_rd_row = row_s1 + RW'(1);
			S_FETCH: begin
				gen_rd_addr = found_q;
				life_rd_row = RW'(found_q >> ROW_SHIFT);
			end
			default: ;
		endcase
	end

	// row scan: lowest dead and lowest free slot within the row just read
	always_comb begin
		row_base = 17'(row_s1) << ROW_SHIFT;
		dead_idx = '0;
		free_idx = '0;
		for (int k = 0; k < ROW_SLOTS; k++) begin
			logic slot_ok;
			logic [1:0] ls;
			slot_ok = (row_base + 17'(k)) < 17'(SLOT_COUNT);
			ls = life_get(life_rd_data, LANE_W'(k));
			dead_v[k] = slot_ok && (ls == LS_DEAD);
			free_v[k] = slot_ok && (ls == LS_FREE);
		end
		for (int k = ROW_SLOTS - 1; k >= 0; k--) begin
			if (dead_v[k]) dead_idx = LANE_W'(k);
			if (free_v[k]) free_idx = LANE_W'(k);
		end
		scan_last = (row_s1 == RW'(ROWS - 1));
	end

	// token check against the stored entry
	always_comb begin
		tok_invalid = !({1'b0, slot_q} < 17'(SLOT_COUNT)) || (gen_q == '0);
		tok_stale   = (gen_rd_data != gen_q);
		cur_life    = life_t'(life_get(life_rd_data, slot_q[LANE_W-1:0]));
		need_life   = (cmd_q == CMD_RETIRE) ? LS_ACTIVE : LS_RETIRING;
		next_life   = (cmd_q == CMD_RETIRE) ? LS_RETIRING : LS_DEAD;
		new_gen     = gen_rd_data + GEN_W'(1);
		if (new_gen == '0) new_gen = GEN_W'(1);
	end

	// execute, write back and count
	always_comb begin
		fin          = 1'b0;
		res_success  = 1'b0;
		res_status   = ST_OK;
		res_gslot    = '0;
		res_ggen     = '0;
		res_reused   = 1'b0;
		res_life     = '0;
		res_cval     = '0;
		gen_wr_en    = 1'b0;
		gen_wr_addr  = found_q;
		gen_wr_data  = new_gen;
		life_wr_en   = 1'b0;
		life_wr_row  = RW'(slot_q >> ROW_SHIFT);
		life_wr_data = life_set(life_rd_data, slot_q[LANE_W-1:0], next_life);
		ctr_ctl      = '0;

		unique case (state_q)
			S_IDLE: begin
				ctr_ctl.clear = start && (cmd_t'(command) == CMD_CLEAR);
			end
			S_EXEC: begin
				fin = 1'b1;
				unique case (cmd_q)
					CMD_RETIRE, CMD_MARK_DEAD: begin
						priority if (tok_invalid) begin
							res_status = ST_INVALID;
							ctr_ctl.inc[CNT_BAD_TRANS] = 1'b1;
						end else if (tok_stale) begin
							res_status = ST_STALE;
							ctr_ctl.inc[CNT_BAD_TRANS] = 1'b1;
						end else if (cur_life != need_life) begin
							res_status = ST_WRONG;
							ctr_ctl.inc[CNT_BAD_TRANS] = 1'b1;
						end else begin
							res_success = 1'b1;
							life_wr_en  = 1'b1;
							if (cmd_q == CMD_RETIRE) ctr_ctl.inc[CNT_RETIRE_OK] = 1'b1;
							else                     ctr_ctl.inc[CNT_DEAD_OK] = 1'b1;
						end
					end
					CMD_PUBLISH: begin
						priority if (tok_invalid) begin
							res_status = ST_INVALID;
							ctr_ctl.inc[CNT_PUB_INVALID] = 1'b1;
						end else if (tok_stale) begin
							res_status = ST_STALE;
							ctr_ctl.inc[CNT_PUB_STALE] = 1'b1;
						end else if (cur_life == LS_ACTIVE || cur_life == LS_RETIRING) begin
							res_success = 1'b1;
							ctr_ctl.inc[CNT_PUB_ACCEPT] = 1'b1;
						end else begin
							res_status = ST_WRONG;
							ctr_ctl.inc[CNT_PUB_DEAD] = 1'b1;
						end
					end
					CMD_QUERY: begin
						priority if (tok_invalid) begin
							res_status = ST_INVALID;
						end else if (tok_stale) begin
							res_status = ST_STALE;
						end else begin
							res_success = 1'b1;
							res_life    = cur_life;
						end
					end
					CMD_READ_CNT: begin
						res_success = (sel_q < CNT_W'(NUM_COUNTERS));
						res_cval    = ctr_value;
					end
					default: ;  // unused code: no effect
				endcase
			end
			S_SCAN: begin
				if (!(|dead_v) && scan_last && !have_free_q && !(|free_v)) begin
					fin        = 1'b1;
					res_status = ST_FULL;
					ctr_ctl.inc[CNT_REG_FULL] = 1'b1;
				end
			end
			S_GRANT: begin
				fin          = 1'b1;
				res_success  = 1'b1;
				res_gslot    = 6'(found_q);
				res_ggen     = new_gen;
				res_reused   = reused_q;
				gen_wr_en    = 1'b1;
				life_wr_en   = 1'b1;
				life_wr_row  = RW'(found_q >> ROW_SHIFT);
				life_wr_data = life_set(life_rd_data, LANE_W'(found_q), LS_ACTIVE);
				ctr_ctl.inc[CNT_REG_OK]    = 1'b1;
				ctr_ctl.inc[CNT_REG_REUSE] = reused_q;
			end
			S_CLEAR: begin
				gen_wr_en    = 1'b1;
				gen_wr_addr  = clr_idx_q;
				gen_wr_data  = '0;
				life_wr_en   = 1'b1;
				life_wr_row  = RW'(clr_idx_q >> ROW_SHIFT);
				life_wr_data = '0;
				if (clr_idx_q == SW'(SLOT_COUNT - 1)) begin
					fin         = clr_reply_q;
					res_success = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_CLEAR;
			cmd_q              <= CMD_REGISTER;
			slot_q             <= '0;
			gen_q              <= '0;
			sel_q              <= '0;
			row_s1             <= '0;
			have_free_q        <= 1'b0;
			free_slot_q        <= '0;
			found_q            <= '0;
			reused_q           <= 1'b0;
			clr_idx_q          <= '0;
			clr_reply_q        <= 1'b0;
			done               <= 1'b0;
			success            <= 1'b0;
			status_code        <= ST_OK;
			granted_slot       <= '0;
			granted_generation <= '0;
			slot_reused        <= 1'b0;
			life_state         <= '0;
			counter_value      <= '0;
		end else begin
			done <= fin;
			if (fin) begin
				success            <= res_success;
				status_code        <= res_status;
				granted_slot       <= res_gslot;
				granted_generation <= res_ggen;
				slot_reused        <= res_reused;
				life_state         <= res_life;
				counter_value      <= res_cval;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q       <= cmd_t'(command);
						slot_q      <= token_slot;
						gen_q       <= token_generation;
						sel_q       <= counter_select;
						row_s1      <= '0;
						have_free_q <= 1'b0;
						reused_q    <= 1'b0;
						unique case (cmd_t'(command))
							CMD_REGISTER: state_q <= S_SCAN;
							CMD_CLEAR: begin
								clr_idx_q   <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= S_CLEAR;
							end
							default: state_q <= S_EXEC;
						endcase
					end
				end
				S_EXEC: state_q <= S_IDLE;
				S_SCAN: begin
					row_s1 <= row_s1 + RW'(1);
					if (|dead_v) begin
						found_q  <= SW'(row_base + 17'(dead_idx));
						reused_q <= 1'b1;
						state_q  <= S_FETCH;
					end else begin
						if (!have_free_q && (|free_v)) begin
							free_slot_q <= SW'(row_base + 17'(free_idx));
							have_free_q <= 1'b1;
						end
						if (scan_last) begin
							if (have_free_q) begin
								found_q <= free_slot_q;
								state_q <= S_FETCH;
							end else if (|free_v) begin
								found_q <= SW'(row_base + 17'(free_idx));
								state_q <= S_FETCH;
							end else begin
								state_q <= S_IDLE;  // table full
							end
						end
					end
				end
				S_FETCH: state_q <= S_GRANT;
				S_GRANT: state_q <= S_IDLE;
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + SW'(1);
					if (clr_idx_q == SW'(SLOT_COUNT - 1)) begin
						clr_reply_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/ghr_checker.sv
// Port-level checks for the generational handle registry, bound to the top level.
// Depends on ghr_pkg (status codes) and generational_handle_registry.
module ghr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        success,
	input logic [2:0]  status_code,
	input logic [31:0] granted_generation,
	input logic        slot_reused
);
	import ghr_pkg::*;

	// a result only closes work that was in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding busy");

	// the result cycle is idle, so the next item can be taken in it
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy in result cycle");

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_success_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && success) |-> (status_code == ST_OK))
		else $error("success with nonzero status");

	// a reused slot always comes with a fresh nonzero generation
	a_reuse_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && slot_reused) |-> (success && granted_generation != 32'd0))
		else $error("reuse without a valid grant");

endmodule

bind generational_handle_registry ghr_checker u_ghr_checker (.*);
